[design/tpq_pkg.sv]
package tpq_pkg;

    localparam int ENTRIES   = 64;
    localparam int ADDR_W    = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int KEY_W     = 48;
    localparam int ID_W      = 32;
    localparam int TIME_W    = 48;
    localparam int WAIT_W    = 32;
    localparam int SLOT_W    = KEY_W + ID_W;
    localparam int ELAPSED_W = TIME_W + 1;
    localparam int DELTA_W   = KEY_W + 2;

    // Millisecond rounding: ceil(delta / 1000) as floor((delta + 999) / 1000).
    // 1000 = 8 * 125, so drop three bits and divide by 125 with a reciprocal
    // multiply split into two half-width products; the estimate is low by at
    // most one and a final compare and subtract corrects it.
    localparam int US_PER_MS  = 1000;
    localparam int NUM_W      = 41;
    localparam int MS_SHIFT   = 3;
    localparam int QN_W       = NUM_W - MS_SHIFT;
    localparam int HALF_W     = QN_W / 2;
    localparam int RECIP_W    = 32;
    localparam int PROD_W     = HALF_W + RECIP_W;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam logic [NUM_W-1:0]    ROUND_UP  = NUM_W'(US_PER_MS - 1);
    localparam logic [QN_W-1:0]     DIV_K     = QN_W'(US_PER_MS >> MS_SHIFT);
    // floor(2^38 / 125)
    localparam logic [RECIP_W-1:0]  RECIP_K   = 32'd2199023255;
    localparam logic signed [DELTA_W-1:0] DELTA_CAP = 50'sd2147483647000;

    localparam logic [ID_W-1:0]   NO_ID      = '1;
    localparam logic [WAIT_W-1:0] INT_MAX    = 32'h7FFF_FFFF;
    localparam logic [WAIT_W-1:0] WAIT_EMPTY = '1;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_REMOVE,
        OP_POP,
        OP_QUERY
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE,
        ST_MISS,
        ST_FULL,
        ST_DUP
    } st_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_HEAD,
        S_HEAD_CHK,
        S_DIV,
        S_RESP
    } state_t;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SCAN,
        CMD_SET_DUP,
        CMD_SET_FULL,
        CMD_SET_MISS,
        CMD_SET_EMPTY,
        CMD_PREP_UP,
        CMD_SHIFT_UP,
        CMD_PLACE,
        CMD_PREP_DN,
        CMD_SHIFT_DN,
        CMD_SHRINK,
        CMD_HEAD_RD,
        CMD_POP_TAKE,
        CMD_Q_TAKE,
        CMD_DIV,
        CMD_EMIT
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic walk_done;
        logic up_done;
        logic hit;
        logic full;
        logic empty;
        logic expired;
        logic need_div;
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage

[design/tpq_if.sv]
interface tpq_req_if;
    import tpq_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [1:0]                opcode;
    logic [ID_W-1:0]           entry_id;
    logic signed [KEY_W-1:0]   rel_expiry;
    logic [TIME_W-1:0]         now_us;
    modport source (output valid, opcode, entry_id, rel_expiry, now_us, input ready);
    modport sink   (input valid, opcode, entry_id, rel_expiry, now_us, output ready);
endinterface

interface tpq_rsp_if;
    import tpq_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [1:0]                status;
    logic [ID_W-1:0]           result_id;
    logic signed [KEY_W-1:0]   expiry_key;
    logic signed [WAIT_W-1:0]  wait_ms;
    modport source (output valid, status, result_id, expiry_key, wait_ms, input ready);
    modport sink   (input valid, status, result_id, expiry_key, wait_ms, output ready);
endinterface

interface tpq_cfg_if;
    import tpq_pkg::*;
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[design/tpq_ram.sv]
module tpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/tpq_ctrl.sv]
module tpq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        in_opcode,
    input  tpq_pkg::dp_stat_t stat,
    output logic              in_ready,
    output tpq_pkg::cmd_t     cmd
);
    import tpq_pkg::*;

    state_t state_reg;
    state_t state_next;
    op_t    in_op;

    assign in_op = op_t'(in_opcode);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd = CMD_LOAD;
                    if (in_op == OP_ADD || in_op == OP_REMOVE)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_HEAD;
                    end
                end
            end
            S_SCAN:
            begin
                if (!stat.walk_done)
                begin
                    cmd = CMD_SCAN;
                end
                else if (stat.op == OP_ADD)
                begin
                    if (stat.hit)
                    begin
                        cmd        = CMD_SET_DUP;
                        state_next = S_RESP;
                    end
                    else if (stat.full)
                    begin
                        cmd        = CMD_SET_FULL;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        cmd        = CMD_PREP_UP;
                        state_next = S_SHIFT_UP;
                    end
                end
                else if (!stat.hit)
                begin
                    cmd        = CMD_SET_MISS;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd        = CMD_PREP_DN;
                    state_next = S_SHIFT_DN;
                end
            end
            S_SHIFT_UP:
            begin
                if (!stat.up_done)
                begin
                    cmd = CMD_SHIFT_UP;
                end
                else
                begin
                    cmd        = CMD_PLACE;
                    state_next = S_RESP;
                end
            end
            S_SHIFT_DN:
            begin
                if (!stat.walk_done)
                begin
                    cmd = CMD_SHIFT_DN;
                end
                else
                begin
                    cmd        = CMD_SHRINK;
                    state_next = S_RESP;
                end
            end
            S_HEAD:
            begin
                cmd        = CMD_HEAD_RD;
                state_next = S_HEAD_CHK;
            end
            S_HEAD_CHK:
            begin
                if (stat.op == OP_POP)
                begin
                    if (!stat.empty && stat.expired)
                    begin
                        cmd        = CMD_POP_TAKE;
                        state_next = S_SHIFT_DN;
                    end
                    else
                    begin
                        cmd        = CMD_SET_MISS;
                        state_next = S_RESP;
                    end
                end
                else if (stat.empty)
                begin
                    cmd        = CMD_SET_EMPTY;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd        = CMD_Q_TAKE;
                    state_next = stat.need_div ? S_DIV : S_RESP;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    cmd = CMD_DIV;
                end
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd        = CMD_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != S_IDLE))
        else $error("accepted transaction did not start work");

    a_emit_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == CMD_EMIT) |-> stat.out_free)
        else $error("result emitted over a pending one");

endmodule

[design/tpq_dp.sv]
module tpq_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tpq_pkg::cmd_t                    cmd,
    output tpq_pkg::dp_stat_t                stat,
    input  logic [1:0]                       in_opcode,
    input  logic [tpq_pkg::ID_W-1:0]         in_entry_id,
    input  logic signed [tpq_pkg::KEY_W-1:0] in_rel_expiry,
    input  logic [tpq_pkg::TIME_W-1:0]       in_now_us,
    input  logic                             cfg_valid,
    input  logic [tpq_pkg::TIME_W-1:0]       cfg_data,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [1:0]                       out_status,
    output logic [tpq_pkg::ID_W-1:0]         out_result_id,
    output logic signed [tpq_pkg::KEY_W-1:0] out_expiry_key,
    output logic signed [tpq_pkg::WAIT_W-1:0] out_wait_ms
);
    import tpq_pkg::*;

    // Control state
    logic [TIME_W-1:0]  base_reg, base_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pv_reg, pv_next;
    logic               out_valid_reg, out_valid_next;

    // Working registers
    op_t                          op_reg, op_next;
    logic [ID_W-1:0]              id_reg, id_next;
    logic signed [KEY_W-1:0]      off_reg, off_next;
    logic signed [ELAPSED_W-1:0]  elapsed_reg, elapsed_next;
    logic [CNT_W-1:0]             idx_reg, idx_next;
    logic [ADDR_W-1:0]            pa_reg, pa_next;
    logic                         hit_reg, hit_next;
    logic [ADDR_W-1:0]            hit_pos_reg, hit_pos_next;
    logic                         posf_reg, posf_next;
    logic [CNT_W-1:0]             ins_pos_reg, ins_pos_next;
    st_t                          res_st_reg, res_st_next;
    logic [ID_W-1:0]              res_id_reg, res_id_next;
    logic signed [KEY_W-1:0]      res_off_reg, res_off_next;
    logic [WAIT_W-1:0]            res_wait_reg, res_wait_next;
    logic [NUM_W-1:0]             num_reg, num_next;
    logic [PROD_W-1:0]            prod_lo_reg, prod_lo_next;
    logic [PROD_W-1:0]            prod_hi_reg, prod_hi_next;
    logic [DIV_CNT_W-1:0]         dcnt_reg, dcnt_next;
    logic [1:0]                   ost_reg, ost_next;
    logic [ID_W-1:0]              oid_reg, oid_next;
    logic signed [KEY_W-1:0]      ooff_reg, ooff_next;
    logic [WAIT_W-1:0]            owait_reg, owait_next;

    // Table memory
    logic                 we;
    logic [ADDR_W-1:0]    waddr, raddr;
    logic [SLOT_W-1:0]    wdata, rdata;

    logic signed [KEY_W-1:0]   rd_key;
    logic [ID_W-1:0]           rd_id;
    logic signed [DELTA_W-1:0] delta;
    logic [CNT_W-1:0]          idx_dec;
    logic                      idx_lt_cnt;
    logic [HALF_W-1:0]         num_lo, num_hi;
    logic [QN_W-1:0]           num_q, quot_mul, quot_rem;
    logic [PROD_W:0]           quot_sum;
    logic [WAIT_W-1:0]         quot_est;

    tpq_ram #(.WIDTH(SLOT_W), .DEPTH(ENTRIES)) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_key     = $signed(rdata[SLOT_W-1:ID_W]);
    assign rd_id      = rdata[ID_W-1:0];
    assign delta      = {{2{rd_key[KEY_W-1]}}, rd_key} - {elapsed_reg[ELAPSED_W-1], elapsed_reg};
    assign idx_dec    = idx_reg - 1'b1;
    assign idx_lt_cnt = idx_reg < count_reg;

    // Divide by 125 on the rounded delta with the low three bits dropped
    assign num_q    = num_reg[NUM_W-1:MS_SHIFT];
    assign num_lo   = num_q[HALF_W-1:0];
    assign num_hi   = num_q[QN_W-1:HALF_W];
    assign quot_sum = {1'b0, prod_hi_reg} + {1'b0, (prod_lo_reg >> HALF_W)};
    assign quot_est = quot_sum[HALF_W+WAIT_W-1:HALF_W];
    assign quot_mul = QN_W'(res_wait_reg) * DIV_K;
    assign quot_rem = num_q - quot_mul;

    assign stat.op        = op_reg;
    assign stat.walk_done = !idx_lt_cnt && !pv_reg;
    assign stat.up_done   = (idx_reg == ins_pos_reg) && !pv_reg;
    assign stat.hit       = hit_reg;
    assign stat.full      = count_reg >= CNT_W'(ENTRIES);
    assign stat.empty     = count_reg == '0;
    assign stat.expired   = delta <= 0;
    assign stat.need_div  = (delta > 0) && (delta <= DELTA_CAP);
    assign stat.div_done  = dcnt_reg == '0;
    assign stat.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        base_next      = cfg_valid ? cfg_data : base_reg;
        count_next     = count_reg;
        pv_next        = pv_reg;
        out_valid_next = out_valid_reg && !out_ready;
        op_next        = op_reg;
        id_next        = id_reg;
        off_next       = off_reg;
        elapsed_next   = elapsed_reg;
        idx_next       = idx_reg;
        pa_next        = pa_reg;
        hit_next       = hit_reg;
        hit_pos_next   = hit_pos_reg;
        posf_next      = posf_reg;
        ins_pos_next   = ins_pos_reg;
        res_st_next    = res_st_reg;
        res_id_next    = res_id_reg;
        res_off_next   = res_off_reg;
        res_wait_next  = res_wait_reg;
        num_next       = num_reg;
        prod_lo_next   = prod_lo_reg;
        prod_hi_next   = prod_hi_reg;
        dcnt_next      = dcnt_reg;
        ost_next       = ost_reg;
        oid_next       = oid_reg;
        ooff_next      = ooff_reg;
        owait_next     = owait_reg;
        we             = 1'b0;
        waddr          = pa_reg;
        wdata          = rdata;
        raddr          = '0;

        unique case (cmd) inside
            CMD_NONE, CMD_HEAD_RD:
            begin
            end
            CMD_LOAD:
            begin
                op_next       = op_t'(in_opcode);
                id_next       = in_entry_id;
                off_next      = in_rel_expiry;
                elapsed_next  = $signed({1'b0, in_now_us}) - $signed({1'b0, base_reg});
                idx_next      = '0;
                pv_next       = 1'b0;
                hit_next      = 1'b0;
                posf_next     = 1'b0;
                ins_pos_next  = count_reg;
                res_st_next   = ST_DONE;
                res_id_next   = NO_ID;
                res_off_next  = '0;
                res_wait_next = '0;
            end
            CMD_SCAN:
            begin
                raddr   = idx_reg[ADDR_W-1:0];
                pv_next = idx_lt_cnt;
                pa_next = idx_reg[ADDR_W-1:0];
                if (idx_lt_cnt)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                if (pv_reg)
                begin
                    if (!hit_reg && rd_id == id_reg)
                    begin
                        hit_next     = 1'b1;
                        hit_pos_next = pa_reg;
                    end
                    // first slot strictly later keeps equal offsets in arrival order
                    if (!posf_reg && rd_key > off_reg)
                    begin
                        posf_next    = 1'b1;
                        ins_pos_next = CNT_W'(pa_reg);
                    end
                end
            end
            CMD_SET_DUP:   res_st_next = ST_DUP;
            CMD_SET_FULL:  res_st_next = ST_FULL;
            CMD_SET_MISS:  res_st_next = ST_MISS;
            CMD_SET_EMPTY:
            begin
                res_st_next   = ST_MISS;
                res_wait_next = WAIT_EMPTY;
            end
            CMD_PREP_UP:
            begin
                idx_next = count_reg;
                pv_next  = 1'b0;
            end
            CMD_SHIFT_UP:
            begin
                raddr = idx_dec[ADDR_W-1:0];
                we    = pv_reg;
                if (idx_reg > ins_pos_reg)
                begin
                    idx_next = idx_dec;
                    pv_next  = 1'b1;
                    pa_next  = idx_reg[ADDR_W-1:0];
                end
                else
                begin
                    pv_next = 1'b0;
                end
            end
            CMD_PLACE:
            begin
                we         = 1'b1;
                waddr      = ins_pos_reg[ADDR_W-1:0];
                wdata      = {off_reg, id_reg};
                count_next = count_reg + 1'b1;
            end
            CMD_PREP_DN:
            begin
                idx_next = CNT_W'(hit_pos_reg) + 1'b1;
                pv_next  = 1'b0;
            end
            CMD_POP_TAKE:
            begin
                res_id_next  = rd_id;
                res_off_next = rd_key;
                idx_next     = CNT_W'(1);
                pv_next      = 1'b0;
            end
            CMD_SHIFT_DN:
            begin
                raddr = idx_reg[ADDR_W-1:0];
                we    = pv_reg;
                if (idx_lt_cnt)
                begin
                    idx_next = idx_reg + 1'b1;
                    pv_next  = 1'b1;
                    pa_next  = idx_dec[ADDR_W-1:0];
                end
                else
                begin
                    pv_next = 1'b0;
                end
            end
            CMD_SHRINK:
            begin
                count_next = count_reg - 1'b1;
            end
            CMD_Q_TAKE:
            begin
                res_id_next  = rd_id;
                res_off_next = rd_key;
                num_next     = delta[NUM_W-1:0] + ROUND_UP;
                dcnt_next    = DIV_CNT_W'(DIV_STEPS);
                if (delta > DELTA_CAP)
                begin
                    res_wait_next = INT_MAX;
                end
                else
                begin
                    res_wait_next = '0;
                end
            end
            CMD_DIV:
            begin
                // low product, high product, estimate, then correct by one
                dcnt_next = dcnt_reg - 1'b1;
                if (dcnt_reg == DIV_CNT_W'(DIV_STEPS))
                begin
                    prod_lo_next = PROD_W'(num_lo) * PROD_W'(RECIP_K);
                end
                else if (dcnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    prod_hi_next = PROD_W'(num_hi) * PROD_W'(RECIP_K);
                end
                else if (dcnt_reg == DIV_CNT_W'(DIV_STEPS - 2))
                begin
                    res_wait_next = quot_est;
                end
                else if (quot_rem >= DIV_K)
                begin
                    res_wait_next = res_wait_reg + 1'b1;
                end
            end
            CMD_EMIT:
            begin
                out_valid_next = 1'b1;
                ost_next       = res_st_reg;
                oid_next       = res_id_reg;
                ooff_next      = res_off_reg;
                owait_next     = res_wait_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            count_reg     <= '0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            base_reg      <= base_next;
            count_reg     <= count_next;
            pv_reg        <= pv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        id_reg       <= id_next;
        off_reg      <= off_next;
        elapsed_reg  <= elapsed_next;
        idx_reg      <= idx_next;
        pa_reg       <= pa_next;
        hit_reg      <= hit_next;
        hit_pos_reg  <= hit_pos_next;
        posf_reg     <= posf_next;
        ins_pos_reg  <= ins_pos_next;
        res_st_reg   <= res_st_next;
        res_id_reg   <= res_id_next;
        res_off_reg  <= res_off_next;
        res_wait_reg <= res_wait_next;
        num_reg      <= num_next;
        prod_lo_reg  <= prod_lo_next;
        prod_hi_reg  <= prod_hi_next;
        dcnt_reg     <= dcnt_next;
        ost_reg      <= ost_next;
        oid_reg      <= oid_next;
        ooff_reg     <= ooff_next;
        owait_reg    <= owait_next;
    end

    assign out_valid      = out_valid_reg;
    assign out_status     = ost_reg;
    assign out_result_id  = oid_reg;
    assign out_expiry_key = ooff_reg;
    assign out_wait_ms    = $signed(owait_reg);

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRIES))
        else $error("entry count beyond table size");

    a_place_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == CMD_PLACE) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow the table");

    a_shrink_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == CMD_SHRINK) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("removal did not shrink the table");

endmodule

[design/timeout_priority_queue_top.sv]
// Timeout priority queue. Holds up to ENTRIES pending timeouts (id plus signed
// microsecond offset from base_time_us) in a table kept sorted by offset, with
// equal offsets in arrival order. Each request transaction on req yields exactly
// one response transaction on rsp: add, remove by id, pop the earliest entry if
// it has expired, or query the earliest entry and the ceiling milliseconds left.
// One request is worked on at a time. Its cost is set by walks over the
// single-write, single-read table memory, one slot a cycle. Add and remove
// scan the table for the id and the insert position; an accepted add then
// shifts the later entries up and a found remove shifts them down. Pop reads
// the head and, when it has expired, shifts the rest down; query reads the
// head and, when a positive wait has to be turned into milliseconds, runs
// the four-step reciprocal divide. A finished response sits in an output
// register, so the next request is taken while it waits. Write base_time_us
// on cfg only while no request is in flight; cfg is always ready.
module timeout_priority_queue_top (
    input  logic     clk,
    input  logic     rst_n,
    tpq_req_if.sink  req,
    tpq_rsp_if.source rsp,
    tpq_cfg_if.sink  cfg
);
    import tpq_pkg::*;

    cmd_t     cmd;
    dp_stat_t stat;
    logic     in_ready;

    // Sequence each operation as a series of datapath commands
    tpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_opcode (req.opcode),
        .stat      (stat),
        .in_ready  (in_ready),
        .cmd       (cmd)
    );

    // Table memory, scan and shift pointers, divider and response register
    tpq_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .in_opcode      (req.opcode),
        .in_entry_id    (req.entry_id),
        .in_rel_expiry  (req.rel_expiry),
        .in_now_us      (req.now_us),
        .cfg_valid      (cfg.valid),
        .cfg_data       (cfg.data),
        .out_ready      (rsp.ready),
        .out_valid      (rsp.valid),
        .out_status     (rsp.status),
        .out_result_id  (rsp.result_id),
        .out_expiry_key (rsp.expiry_key),
        .out_wait_ms    (rsp.wait_ms)
    );

    assign req.ready = in_ready;
    // Take configuration transactions at any time
    assign cfg.ready = 1'b1;

endmodule

[dv/tb_if.sv]
// The testbench drives the block through the design interfaces directly.

[dv/testbench.sv]
module testbench;
    import tpq_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // clock: invert every half period of 6 units
    always #6 clk = ~clk;

    tpq_req_if req ();
    tpq_rsp_if rsp ();
    tpq_cfg_if cfg ();

    timeout_priority_queue_top u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    typedef struct {
        op_t                     op;
        logic [ID_W-1:0]         id;
        logic signed [KEY_W-1:0] off;
        logic [TIME_W-1:0]       now;
    } timer_req_t;

    typedef struct {
        st_t                      status;
        logic [ID_W-1:0]          id;
        logic signed [KEY_W-1:0]  off;
        logic signed [WAIT_W-1:0] wait_ms;
    } timer_rsp_t;

    // shadow of the sorted timer table
    longint            tbl_key[$];
    logic [ID_W-1:0]   tbl_id[$];
    logic [TIME_W-1:0] base_us;

    timer_req_t pending_reqs[$];
    timer_rsp_t due_rsps[$];

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  recv_hold;
    int  mismatches;
    int  rsp_count;
    int  op_seen[4];
    longint cycles = 0;
    logic [ID_W-1:0] id_pool[16];

    // work out the response for one accepted request and update the table
    function automatic timer_rsp_t timer_predict(timer_req_t r);
        timer_rsp_t o;
        longint elapsed;
        longint delta;
        longint ms;
        int pos;
        int hit;
        o.status  = ST_DONE;
        o.id      = NO_ID;
        o.off     = '0;
        o.wait_ms = '0;
        elapsed = longint'({16'd0, r.now}) - longint'({16'd0, base_us});
        hit = -1;
        foreach (tbl_id[i])
        begin
            if (hit < 0 && tbl_id[i] == r.id)
                hit = i;
        end
        case (r.op)
            OP_ADD:
            begin
                if (hit >= 0)
                    o.status = ST_DUP;
                else if (tbl_id.size() >= ENTRIES)
                    o.status = ST_FULL;
                else
                begin
                    pos = 0;
                    while (pos < tbl_key.size() && tbl_key[pos] <= longint'(r.off))
                        pos++;
                    tbl_key.insert(pos, longint'(r.off));
                    tbl_id.insert(pos, r.id);
                end
            end
            OP_REMOVE:
            begin
                if (hit < 0)
                    o.status = ST_MISS;
                else
                begin
                    tbl_key.delete(hit);
                    tbl_id.delete(hit);
                end
            end
            OP_POP:
            begin
                if (tbl_id.size() > 0 && tbl_key[0] <= elapsed)
                begin
                    o.id  = tbl_id.pop_front();
                    o.off = KEY_W'(tbl_key.pop_front());
                end
                else
                    o.status = ST_MISS;
            end
            default:
            begin
                if (tbl_id.size() > 0)
                begin
                    o.id  = tbl_id[0];
                    o.off = KEY_W'(tbl_key[0]);
                    delta = tbl_key[0] - elapsed;
                    if (delta > 0)
                    begin
                        ms = (delta + 999) / 1000;
                        o.wait_ms = (ms > 64'sd2147483647) ? INT_MAX : WAIT_W'(ms);
                    end
                end
                else
                begin
                    o.status  = ST_MISS;
                    o.wait_ms = WAIT_EMPTY;
                end
            end
        endcase
        return o;
    endfunction

    function automatic logic signed [KEY_W-1:0] rand_off();
        case ($urandom_range(0, 5))
            0:       return KEY_W'({$urandom(), $urandom()});
            1:       return KEY_W'($signed($urandom_range(0, 200000)) - 100000);
            2:       return KEY_W'($urandom_range(0, 3000));
            default: return KEY_W'($urandom_range(0, 50000000));
        endcase
    endfunction

    // queue one request
    task automatic push_req(op_t op, logic [ID_W-1:0] id,
                            logic signed [KEY_W-1:0] off, logic [TIME_W-1:0] now);
        timer_req_t r;
        r.op  = op;
        r.id  = id;
        r.off = off;
        r.now = now;
        pending_reqs.push_back(r);
    endtask

    // wait for the block to drain everything in flight, then a settle period
    task automatic drain();
        while (pending_reqs.size() != 0 || req.valid || due_rsps.size() != 0)
            @(posedge clk);
        repeat (2 * ENTRIES + 20) @(posedge clk);
    endtask

    task automatic write_base(logic [TIME_W-1:0] v);
        cfg.valid <= 1'b1;
        cfg.data  <= v;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        base_us = v;
    endtask

    task automatic random_phase(int n);
        op_t op;
        logic [ID_W-1:0] id;
        logic [TIME_W-1:0] now;
        for (int k = 0; k < n; k++)
        begin
            // bias towards adds so the table fills and empties in turn
            case ($urandom_range(0, 9))
                0, 1, 2, 3: op = OP_ADD;
                4, 5:       op = OP_REMOVE;
                6, 7:       op = OP_POP;
                default:    op = OP_QUERY;
            endcase
            id = ($urandom_range(0, 9) == 0) ? $urandom() : id_pool[$urandom_range(0, 15)];
            if ($urandom_range(0, 7) == 0)
                now = TIME_W'({$urandom(), $urandom()});
            else
                now = base_us + TIME_W'($urandom_range(0, 60000000));
            push_req(op, id, rand_off(), now);
        end
    endtask

    // driver: present the head of the pending queue, advancing on accept
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid      <= 1'b0;
            req.opcode     <= OP_ADD;
            req.entry_id   <= '0;
            req.rel_expiry <= '0;
            req.now_us     <= '0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                due_rsps.push_back(timer_predict(pending_reqs[0]));
                op_seen[pending_reqs[0].op]++;
                void'(pending_reqs.pop_front());
            end
            if (!req.valid || req.ready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    req.valid      <= 1'b1;
                    req.opcode     <= pending_reqs[0].op;
                    req.entry_id   <= pending_reqs[0].id;
                    req.rel_expiry <= pending_reqs[0].off;
                    req.now_us     <= pending_reqs[0].now;
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // monitor: check each response transaction against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        timer_rsp_t e;
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                rsp_count++;
                if (due_rsps.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response: st=%0d id=%h", rsp.status, rsp.result_id);
                end
                else
                begin
                    e = due_rsps.pop_front();
                    if (rsp.status !== e.status || rsp.result_id !== e.id ||
                        rsp.expiry_key !== e.off || rsp.wait_ms !== e.wait_ms)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp st=%0d id=%h off=%0d wait=%0d,",
                                      " got st=%0d id=%h off=%0d wait=%0d"},
                                     e.status, e.id, e.off, e.wait_ms, rsp.status,
                                     rsp.result_id, rsp.expiry_key, rsp.wait_ms);
                    end
                end
            end
            rsp.ready <= !recv_hold && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 3000000)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("** timeout_priority_queue_top: FAILED **");
            $finish;
        end
    end

    initial
    begin
        mismatches = 0;
        rsp_count = 0;
        recv_hold = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        base_us = '0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        foreach (op_seen[i])
            op_seen[i] = 0;
        foreach (id_pool[i])
            id_pool[i] = $urandom();
        id_pool[0] = '0;
        id_pool[1] = NO_ID;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extremes, duplicates, equal keys, removal miss
        push_req(OP_QUERY, '0, '0, '0);
        push_req(OP_POP, '0, '0, '1);
        push_req(OP_REMOVE, NO_ID, '0, '0);
        push_req(OP_ADD, NO_ID, {1'b0, {(KEY_W-1){1'b1}}}, '0);
        push_req(OP_ADD, '0, {1'b1, {(KEY_W-1){1'b0}}}, '0);
        push_req(OP_ADD, 32'd5, 48'sd1500, '0);
        push_req(OP_ADD, 32'd6, 48'sd1500, '0);
        push_req(OP_ADD, 32'd5, 48'sd7, '0);
        push_req(OP_QUERY, '0, '0, 48'd0);
        push_req(OP_POP, '0, '0, 48'd0);
        push_req(OP_QUERY, '0, '0, 48'd1);
        push_req(OP_QUERY, '0, '0, 48'd1500);
        push_req(OP_POP, '0, '0, 48'd1499);
        push_req(OP_POP, '0, '0, 48'd1500);
        push_req(OP_POP, '0, '0, 48'd1500);
        push_req(OP_REMOVE, NO_ID, '0, '0);
        push_req(OP_QUERY, '0, '0, '0);
        push_req(OP_REMOVE, 32'd99, '0, '0);
        drain();

        // fill the table past capacity, then empty it again
        for (int i = 0; i <= ENTRIES; i++)
            push_req(OP_ADD, 32'h1000 + i, KEY_W'($urandom_range(0, 40)), '0);
        for (int i = 0; i <= ENTRIES; i++)
            push_req(OP_POP, '0, '0, '1);
        drain();

        // phase one: sender idles 30 percent, receiver 66; large base
        send_idle_pct = 30;
        recv_idle_pct = 66;
        write_base('1);
        random_phase(650);
        drain();

        // phase two: roles swapped, base at 0x8000_0000, with a long stall
        send_idle_pct = 66;
        recv_idle_pct = 30;
        write_base(48'h0000_8000_0000);
        random_phase(650);
        recv_hold = 1'b1;
        repeat (600) @(posedge clk);
        recv_hold = 1'b0;
        drain();

        // phase three: no idling, base back to zero
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_base('0);
        random_phase(700);
        drain();

        $display("covered %0d responses: add %0d, remove %0d, pop %0d, query %0d",
                 rsp_count, op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
        $display("three base settings, full table, long receiver stall");
        if (mismatches == 0 && due_rsps.size() == 0)
            $display("** timeout_priority_queue_top: PASSED **");
        else
            $display("** timeout_priority_queue_top: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
design/tpq_pkg.sv
design/tpq_if.sv
design/tpq_ram.sv
design/tpq_ctrl.sv
design/tpq_dp.sv
design/timeout_priority_queue_top.sv
dv/tb_if.sv
dv/testbench.sv
